>>> rtl/dts_pkg.sv
// Shared types and constants of the topological sort unit.
package dts_pkg;

  localparam int unsigned FieldW = 6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SORT = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_CNT_RD,
    ST_CNT_ACC,
    ST_SEED,
    ST_SEED_SCAN,
    ST_POP,
    ST_POP_WAIT,
    ST_REL,
    ST_REL_SCAN,
    ST_EMIT,
    ST_EMIT_NONE
  } state_e;

  typedef struct packed {
    logic take_in;
    logic sort_start;
    logic ld_rd;
    logic ld_wr;
    logic cnt_rd;
    logic cnt_acc;
    logic seed;
    logic scan;
    logic pop;
    logic pop_wait;
    logic rel;
    logic emit;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic ld_ok;
    logic row_last;
    logic scan_last;
    logic stack_empty;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/dag_topological_sort_unit.sv
// Top level of the topological sort unit: stream ports, register port and submodules.
// The unit keeps a directed adjacency bit matrix in a row memory and sorts it with
// Kahn's algorithm on a LIFO ready stack. A load request (tuser 0) writes one matrix
// entry with one memory read and one row write. A sort request (tuser 1) counts
// in-degrees one matrix row at a time, in a read state and an accumulate state per
// row, scans the n active vertices one per cycle to seed the stack, and then, for each
// ordered vertex, pops it and reads its row, releases its successors in a scan over
// the n active vertices and hands over the result, waiting while the result stream is
// stalled. One request is worked on at a time. The matrix reads as all zero after
// reset, with no clearing pass. The last result of a sort carries tlast, and tuser
// bit 1 on it reports a cycle in the graph.
module dag_topological_sort_unit #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // src_vertex[5:0], dst_vertex[11:6], edge_present[12]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // vertex_id[5:0], order_position[11:6]
  output logic [1:0]  m_axis_tuser,   // has_vertex[0], cycle_found[1]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dts_pkg::cmd_t               cmd;
  dts_pkg::stat_t              stat;
  logic [6:0]                  vertex_count_q;
  logic [dts_pkg::FieldW-1:0]  out_vertex, out_pos;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[2] == dts_pkg::REG_VERTEX_COUNT)) begin
      vertex_count_q <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == dts_pkg::REG_VERTEX_COUNT) ? {25'd0, vertex_count_q} : 32'd0;

  dts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  dts_datapath #(
    .MaxVertices(MAX_VERTICES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_valid_i    (s_axis_tvalid),
    .in_op_i       (s_axis_tuser[0]),
    .in_src_i      (s_axis_tdata[5:0]),
    .in_dst_i      (s_axis_tdata[11:6]),
    .in_edge_i     (s_axis_tdata[12]),
    .vertex_count_i(vertex_count_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_vertex_o  (out_vertex),
    .out_pos_o     (out_pos),
    .out_has_o     (m_axis_tuser[0]),
    .out_cycle_o   (m_axis_tuser[1]),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_pos, out_vertex};

endmodule

>>> rtl/dts_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dts_ctrl.sv
// Controller state machine that sequences loads and the sort passes.
module dts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dts_pkg::stat_t stat_i,
  output dts_pkg::cmd_t  cmd_o,
  output logic           in_ready_o
);

  dts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.take_in = 1'b1;
          if (stat_i.in_op == dts_pkg::OP_SORT) begin
            cmd_o.sort_start = 1'b1;
            state_d          = dts_pkg::ST_CNT_RD;
          end else begin
            state_d = dts_pkg::ST_LD_RD;
          end
        end
      end
      dts_pkg::ST_LD_RD: begin
        cmd_o.ld_rd = 1'b1;
        state_d     = stat_i.ld_ok ? dts_pkg::ST_LD_WR : dts_pkg::ST_IDLE;
      end
      dts_pkg::ST_LD_WR: begin
        cmd_o.ld_wr = 1'b1;
        state_d     = dts_pkg::ST_IDLE;
      end
      dts_pkg::ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = dts_pkg::ST_CNT_ACC;
      end
      dts_pkg::ST_CNT_ACC: begin
        cmd_o.cnt_acc = 1'b1;
        state_d       = stat_i.row_last ? dts_pkg::ST_SEED : dts_pkg::ST_CNT_RD;
      end
      dts_pkg::ST_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = dts_pkg::ST_SEED_SCAN;
      end
      dts_pkg::ST_SEED_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = dts_pkg::ST_POP;
        end
      end
      dts_pkg::ST_POP: begin
        if (stat_i.stack_empty) begin
          state_d = dts_pkg::ST_EMIT_NONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = dts_pkg::ST_POP_WAIT;
        end
      end
      dts_pkg::ST_POP_WAIT: begin
        cmd_o.pop_wait = 1'b1;
        state_d        = dts_pkg::ST_REL;
      end
      dts_pkg::ST_REL: begin
        cmd_o.rel = 1'b1;
        state_d   = dts_pkg::ST_REL_SCAN;
      end
      dts_pkg::ST_REL_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = dts_pkg::ST_EMIT;
        end
      end
      dts_pkg::ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.stack_empty ? dts_pkg::ST_IDLE : dts_pkg::ST_POP;
        end
      end
      dts_pkg::ST_EMIT_NONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit_none = 1'b1;
          state_d         = dts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dts_datapath.sv
// Datapath: adjacency memory, in-degree counters, ready stack and result register.
module dts_datapath #(
  parameter int unsigned MaxVertices = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dts_pkg::cmd_t                cmd_i,
  output dts_pkg::stat_t               stat_o,
  input  logic                         in_valid_i,
  input  logic                         in_op_i,
  input  logic [dts_pkg::FieldW-1:0]   in_src_i,
  input  logic [dts_pkg::FieldW-1:0]   in_dst_i,
  input  logic                         in_edge_i,
  input  logic [6:0]                   vertex_count_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [dts_pkg::FieldW-1:0]   out_vertex_o,
  output logic [dts_pkg::FieldW-1:0]   out_pos_o,
  output logic                         out_has_o,
  output logic                         out_cycle_o,
  output logic                         out_last_o
);

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned NW = $clog2(MaxVertices + 1);

  logic [6:0]                 n_full;
  logic [NW-1:0]              n;
  logic [MaxVertices-1:0]     col_en;

  logic [dts_pkg::FieldW-1:0] src_q, dst_q;
  logic                       edge_q;
  logic                       ld_ok;

  logic [AW-1:0]              row_q, scan_q, v_q;
  logic [NW-1:0]              depth_q, count_q, depth_m1;
  logic [MaxVertices-1:0]     mask_q;
  logic [NW-1:0]              indeg_q [MaxVertices];
  logic [MaxVertices-1:0]     valid_q;
  logic                       rd_valid_q;

  logic [AW-1:0]              adj_raddr;
  logic [MaxVertices-1:0]     adj_rdata, row_bits, bit_sel, adj_wdata;
  logic                       adj_we;
  logic [AW-1:0]              stk_rdata;
  logic                       push;

  logic [MaxVertices-1:0]     rel_hit, rel_zero, seed_zero;

  logic                       out_valid_q, out_has_q, out_cycle_q, out_last_q;
  logic [dts_pkg::FieldW-1:0] out_vertex_q, out_pos_q;
  logic                       out_busy;

  assign n_full = (vertex_count_i == 7'd0) ? 7'd1 :
                  (vertex_count_i > 7'(MaxVertices)) ? 7'(MaxVertices) : vertex_count_i;
  assign n      = NW'(n_full);

  assign ld_ok = ({1'b0, src_q} < 7'(MaxVertices)) && ({1'b0, dst_q} < 7'(MaxVertices));

  always_comb begin
    if (cmd_i.pop_wait) begin
      adj_raddr = stk_rdata;
    end else if (cmd_i.cnt_rd) begin
      adj_raddr = row_q;
    end else begin
      adj_raddr = src_q[AW-1:0];
    end
  end

  assign row_bits  = rd_valid_q ? adj_rdata : '0;
  assign bit_sel   = MaxVertices'(1) << dst_q[AW-1:0];
  assign adj_wdata = edge_q ? (row_bits | bit_sel) : (row_bits & ~bit_sel);
  assign adj_we    = cmd_i.ld_wr & ld_ok;

  dts_ram #(
    .Width(MaxVertices),
    .Depth(MaxVertices)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(src_q[AW-1:0]),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  assign push     = cmd_i.scan & mask_q[0] & (depth_q < NW'(MaxVertices));
  assign depth_m1 = depth_q - NW'(1);

  dts_ram #(
    .Width(AW),
    .Depth(MaxVertices)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(depth_q[AW-1:0]),
    .wdata_i(scan_q),
    .raddr_i(depth_m1[AW-1:0]),
    .rdata_o(stk_rdata)
  );

  for (genvar g = 0; g < MaxVertices; g++) begin : g_col
    assign col_en[g]    = (NW'(g) < n);
    assign rel_hit[g]   = row_bits[g] & col_en[g] & (indeg_q[g] != '0);
    assign rel_zero[g]  = rel_hit[g] & (indeg_q[g] == NW'(1));
    assign seed_zero[g] = col_en[g] & (indeg_q[g] == '0);

    always_ff @(posedge clk_i) begin
      if (cmd_i.sort_start) begin
        indeg_q[g] <= '0;
      end else if (cmd_i.cnt_acc && row_bits[g] && col_en[g]) begin
        indeg_q[g] <= indeg_q[g] + NW'(1);
      end else if (cmd_i.rel && rel_hit[g]) begin
        indeg_q[g] <= indeg_q[g] - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[adj_raddr];
      if (adj_we) begin
        valid_q[src_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      src_q  <= in_src_i;
      dst_q  <= in_dst_i;
      edge_q <= in_edge_i;
    end
    if (cmd_i.pop_wait) begin
      v_q <= stk_rdata;
    end
    if (cmd_i.seed) begin
      mask_q <= seed_zero;
    end else if (cmd_i.rel) begin
      mask_q <= rel_zero;
    end else if (cmd_i.scan) begin
      mask_q <= mask_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      scan_q  <= '0;
      depth_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.sort_start) begin
        row_q <= '0;
      end else if (cmd_i.cnt_acc) begin
        row_q <= row_q + AW'(1);
      end
      if (cmd_i.seed || cmd_i.rel) begin
        scan_q <= '0;
      end else if (cmd_i.scan) begin
        scan_q <= scan_q + AW'(1);
      end
      if (cmd_i.sort_start) begin
        depth_q <= '0;
      end else if (push) begin
        depth_q <= depth_q + NW'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_m1;
      end
      if (cmd_i.sort_start) begin
        count_q <= '0;
      end else if (cmd_i.emit) begin
        count_q <= count_q + NW'(1);
      end
    end
  end

  assign out_busy = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_none) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_vertex_q <= dts_pkg::FieldW'(v_q);
      out_pos_q    <= dts_pkg::FieldW'(count_q);
      out_has_q    <= 1'b1;
      out_last_q   <= (depth_q == '0);
      out_cycle_q  <= (depth_q == '0) && ((count_q + NW'(1)) < n);
    end else if (cmd_i.emit_none) begin
      out_vertex_q <= '0;
      out_pos_q    <= '0;
      out_has_q    <= 1'b0;
      out_last_q   <= 1'b1;
      out_cycle_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_pos_o    = out_pos_q;
  assign out_has_o    = out_has_q;
  assign out_cycle_o  = out_cycle_q;
  assign out_last_o   = out_last_q;

  assign stat_o.in_valid    = in_valid_i;
  assign stat_o.in_op       = in_op_i;
  assign stat_o.ld_ok       = ld_ok;
  assign stat_o.row_last    = (NW'(row_q) == (n - NW'(1)));
  assign stat_o.scan_last   = (NW'(scan_q) == (n - NW'(1)));
  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.out_busy    = out_busy;

endmodule
